// ===== hw/rtl/three_tap_sinc_resampler_top_macros.svh =====
// Assertion macros for the three-tap sinc resampler.
// Modules that use them must have clk and rst in scope.
`ifndef THREE_TAP_SINC_RESAMPLER_TOP_MACROS_SVH
`define THREE_TAP_SINC_RESAMPLER_TOP_MACROS_SVH
`ifndef SYNTH
// Checked outside reset
`define TSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every edge, reset included
`define TSR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TSR_ASSERT(lbl, prop, msg)
`define TSR_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== hw/rtl/tsr_pkg.sv =====
// Shared types, constants and the sinc weight function of the resampler.
// No dependencies.
package tsr_pkg;

  localparam int SAMPLE_W = 16;
  localparam int WEIGHT_W = 17;
  localparam int STEP_W   = 21;
  localparam int POS_W    = 48;
  localparam int COUNT_W  = 32;
  localparam int FRAC_W   = 16;
  localparam int ACC_W    = 35;
  localparam logic [STEP_W-1:0] STEP_RESET = 21'd65536;
  localparam longint Q24_ONE = 64'sd16777216;
  localparam int SERIES_TERMS = 20;

  // (2n+2)(2n+3) for each term of the series
  localparam longint SERIES_DIV [SERIES_TERMS] = '{
    6, 20, 42, 72, 110, 156, 210, 272, 342, 420,
    506, 600, 702, 812, 930, 1056, 1190, 1332, 1482, 1640
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MAC,
    ST_SAT
  } state_t;

  localparam logic [1:0] TAP_OLD = 2'd0;
  localparam logic [1:0] TAP_MID = 2'd1;
  localparam logic [1:0] TAP_NEW = 2'd2;

  typedef struct packed {
    logic en;
    logic first;
  } mac_ctrl_t;

  // sin(c*t)/(c*t) in Q1.15 with c = 3.142, t = a / 2^pb; Taylor series in Q24
  function automatic logic signed [WEIGHT_W-1:0] sinc_q15(input longint unsigned a,
                                                          input int pb);
    longint unsigned theta;
    longint t2;
    longint term;
    longint sum;
    longint mag;
    longint q;
    theta = (((64'd3142 * a) << 24) / 64'd1000) >> pb;
    t2 = longint'((theta * theta) >> 24);
    term = Q24_ONE;
    sum = Q24_ONE;
    for (int n = 0; n < SERIES_TERMS; n++) begin
      term = -((term * t2) / Q24_ONE);
      term = term / SERIES_DIV[n];
      sum = sum + term;
    end
    mag = (sum < 0) ? -sum : sum;
    q = (mag + 256) >>> 9;
    if (q > 32768) q = 32768;
    if (sum < 0) q = -q;
    return WEIGHT_W'(q);
  endfunction

endpackage

// ===== hw/rtl/tsr_ifs.sv =====
// Valid/ready stream interfaces for the resampler's sample input and output.
// Depends on tsr_pkg.
interface tsr_in_if;
  import tsr_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       end_of_data;

  modport source (output valid, output sample_in, output end_of_data, input ready);
  modport sink (input valid, input sample_in, input end_of_data, output ready);
endinterface

interface tsr_out_if;
  import tsr_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       clipped;
  logic                       last_of_run;

  modport source (output valid, output sample_out, output clipped, output last_of_run,
                  input ready);
  modport sink (input valid, input sample_out, input clipped, input last_of_run,
                output ready);
endinterface

// ===== hw/rtl/three_tap_sinc_resampler_top.sv =====
// Three-tap sinc resampler: one input sample per transaction, zero to 2*MAX_UPSAMPLE outputs.
// Each output goes through a position check, one MAC step per tap on the shared multiplier
// and a saturate step; an end-of-data item adds a flush pass that pushes a zero sample.
// Input ready only while idle; outputs pass through a one-entry hold and an output register.
// Synchronous reset clears history, count, position, phase_step (to 1.0) and all valids.
`include "three_tap_sinc_resampler_top_macros.svh"
module three_tap_sinc_resampler_top #(
  parameter int PHASE_BITS   = 8,
  parameter int MAX_UPSAMPLE = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  tsr_in_if.sink                            din,
  tsr_out_if.source                         dout,
  input  logic                              cfg_we,
  input  logic [tsr_pkg::STEP_W-1:0]        cfg_data
);
  import tsr_pkg::*;

  localparam int MIN_STEP = (65536 + MAX_UPSAMPLE - 1) / MAX_UPSAMPLE;
  localparam int MADE_W   = $clog2(MAX_UPSAMPLE + 1);
  localparam logic [MADE_W-1:0] MADE_MAX = MADE_W'(MAX_UPSAMPLE);

  state_t state;
  state_t state_next;

  logic [STEP_W-1:0]         phase_step;
  logic signed [SAMPLE_W-1:0] hist0;
  logic signed [SAMPLE_W-1:0] hist1;
  logic signed [SAMPLE_W-1:0] hist2;
  logic [COUNT_W-1:0]        input_count;
  logic [POS_W-1:0]          pos;
  logic [POS_W-1:0]          limit;
  logic [MADE_W-1:0]         made;
  logic                      flush;
  logic                      last_item;
  logic [1:0]                tap;
  logic                      pend_valid;
  logic signed [SAMPLE_W-1:0] pend_y;
  logic                      pend_clip;
  logic                      out_valid;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                      out_clip;
  logic                      out_last;

  logic [POS_W-1:0]          pos_gap;
  logic                      go;
  logic                      out_free;
  logic [STEP_W-1:0]         step_eff;
  logic [PHASE_BITS-1:0]     phase;
  logic                      accept;
  logic                      start;
  logic                      to_flush;
  logic                      finish;
  logic                      emit;
  logic                      emit_last;
  logic [1:0]                rom_tap;
  mac_ctrl_t                 mac_ctrl;
  logic signed [SAMPLE_W-1:0] mac_sample;
  logic signed [WEIGHT_W-1:0] weight;
  logic signed [SAMPLE_W-1:0] mac_y;
  logic                      mac_clip;

  tsr_rom #(
    .PHASE_BITS(PHASE_BITS)
  ) u_rom (
    .clk    (clk),
    .tap    (rom_tap),
    .phase  (phase),
    .weight (weight)
  );

  tsr_mac u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .sample (mac_sample),
    .weight (weight),
    .y      (mac_y),
    .clip   (mac_clip)
  );

  // Wrapping distance to the limit; a set top bit means the position is past it
  assign pos_gap  = limit - pos;
  assign go       = (pos_gap != '0) && !pos_gap[POS_W-1] && (made != MADE_MAX);
  assign out_free = !out_valid || dout.ready;
  assign step_eff = (phase_step < STEP_W'(MIN_STEP)) ? STEP_W'(MIN_STEP) : phase_step;
  assign phase    = pos[FRAC_W-1 -: PHASE_BITS];

  always_comb begin
    case (tap)
      TAP_OLD: mac_sample = hist2;
      TAP_MID: mac_sample = hist1;
      TAP_NEW: mac_sample = hist0;
      default: mac_sample = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    accept     = 1'b0;
    start      = 1'b0;
    to_flush   = 1'b0;
    finish     = 1'b0;
    emit       = 1'b0;
    emit_last  = 1'b0;
    mac_ctrl   = '0;
    rom_tap    = TAP_OLD;
    case (state)
      ST_IDLE: begin
        if (din.valid) begin
          accept     = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (go) begin
          // Release the held result as not-last before starting the next one
          if (!pend_valid || out_free) begin
            emit       = pend_valid;
            start      = 1'b1;
            state_next = ST_MAC;
          end
        end else if (last_item && !flush) begin
          to_flush = 1'b1;
        end else if (!pend_valid || out_free) begin
          emit       = pend_valid;
          emit_last  = 1'b1;
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_MAC: begin
        mac_ctrl.en    = 1'b1;
        mac_ctrl.first = (tap == TAP_OLD);
        rom_tap        = tap + 2'd1;
        if (tap == TAP_NEW) begin
          state_next = ST_SAT;
        end
      end
      ST_SAT: begin
        state_next = ST_CHECK;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step  <= STEP_RESET;
      hist0       <= '0;
      hist1       <= '0;
      hist2       <= '0;
      input_count <= '0;
      pos         <= '0;
      limit       <= '0;
      made        <= '0;
      flush       <= 1'b0;
      last_item   <= 1'b0;
      tap         <= TAP_OLD;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        phase_step <= cfg_data;
      end
      if (accept) begin
        hist2     <= hist1;
        hist1     <= hist0;
        hist0     <= din.sample_in;
        limit     <= {input_count, {FRAC_W{1'b0}}};
        made      <= '0;
        flush     <= 1'b0;
        last_item <= din.end_of_data;
      end
      // Flush: push a zero sample and extend the limit by one input
      if (to_flush) begin
        hist2 <= hist1;
        hist1 <= hist0;
        hist0 <= '0;
        limit <= {input_count + COUNT_W'(1), {FRAC_W{1'b0}}};
        made  <= '0;
        flush <= 1'b1;
      end
      if (start) begin
        tap <= TAP_OLD;
      end else if (state == ST_MAC) begin
        tap <= tap + 2'd1;
      end
      if (state == ST_SAT) begin
        pend_valid <= 1'b1;
        pos        <= pos + POS_W'(step_eff);
        made       <= made + MADE_W'(1);
      end else if (emit) begin
        pend_valid <= 1'b0;
      end
      if (finish) begin
        if (last_item) begin
          hist0       <= '0;
          hist1       <= '0;
          hist2       <= '0;
          input_count <= '0;
          pos         <= '0;
        end else begin
          input_count <= input_count + COUNT_W'(1);
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SAT) begin
      pend_y    <= mac_y;
      pend_clip <= mac_clip;
    end
    if (emit) begin
      out_sample <= pend_y;
      out_clip   <= pend_clip;
      out_last   <= emit_last;
    end
  end

  assign din.ready        = (state == ST_IDLE);
  assign dout.valid       = out_valid;
  assign dout.sample_out  = out_sample;
  assign dout.clipped     = out_clip;
  assign dout.last_of_run = out_last;

  `TSR_ASSERT(a_no_pend_overwrite, (state == ST_MAC) |-> !pend_valid, "held result not released")
  `TSR_ASSERT(a_made_bound, made <= MADE_MAX, "too many outputs for one pass")
  `TSR_ASSERT(a_end_clears, (finish && last_item) |=> (input_count == '0 && pos == '0), "stream not cleared")
  `TSR_ASSERT_RST(a_reset_state, rst |=> (state == ST_IDLE && pos == '0 && !pend_valid), "reset state")

endmodule

// ===== hw/rtl/tsr_rom.sv =====
// Weight ROM: three sinc weights per phase, built at elaboration, registered read.
// Depends on tsr_pkg.
module tsr_rom #(
  parameter int PHASE_BITS = 8
) (
  input  logic                                clk,
  input  logic [1:0]                          tap,
  input  logic [PHASE_BITS-1:0]               phase,
  output logic signed [tsr_pkg::WEIGHT_W-1:0] weight
);
  import tsr_pkg::*;

  localparam int SPAN = 1 << PHASE_BITS;

  typedef logic signed [WEIGHT_W-1:0] wrom_t [4*SPAN];

  // Rows: w(t+1), w(t), w(1-t); the fourth row is zero
  function automatic wrom_t build_rom();
    wrom_t r;
    for (int k = 0; k < SPAN; k++) begin
      r[k]            = sinc_q15(longint'(k + SPAN), PHASE_BITS);
      r[SPAN + k]     = sinc_q15(longint'(k), PHASE_BITS);
      r[2 * SPAN + k] = sinc_q15(longint'(SPAN - k), PHASE_BITS);
      r[3 * SPAN + k] = '0;
    end
    return r;
  endfunction

  localparam wrom_t WROM = build_rom();

  always_ff @(posedge clk) begin
    weight <= WROM[{tap, phase}];
  end

endmodule

// ===== hw/rtl/tsr_mac.sv =====
// Shared multiply-accumulate unit with truncating divide by 2^15 and saturation.
// Depends on tsr_pkg.
module tsr_mac (
  input  logic                                clk,
  input  tsr_pkg::mac_ctrl_t                  ctrl,
  input  logic signed [tsr_pkg::SAMPLE_W-1:0] sample,
  input  logic signed [tsr_pkg::WEIGHT_W-1:0] weight,
  output logic signed [tsr_pkg::SAMPLE_W-1:0] y,
  output logic                                clip
);
  import tsr_pkg::*;

  localparam int PROD_W = SAMPLE_W + WEIGHT_W;
  localparam logic signed [ACC_W-1:0] Y_MAX  = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] Y_MIN  = -ACC_W'(32768);
  localparam logic signed [ACC_W-1:0] BIAS   = ACC_W'(32767);

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  biased;
  logic signed [ACC_W-1:0]  quo;

  assign prod = sample * weight;

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      acc <= (ctrl.first ? '0 : acc) + ACC_W'(prod);
    end
  end

  // Round toward zero: bias negative sums before the arithmetic shift
  always_comb begin
    biased = acc + (acc[ACC_W-1] ? BIAS : '0);
    quo    = biased >>> 15;
    clip   = (quo > Y_MAX) || (quo < Y_MIN);
    if (quo > Y_MAX) begin
      y = 16'sh7fff;
    end else if (quo < Y_MIN) begin
      y = -16'sh8000;
    end else begin
      y = quo[SAMPLE_W-1:0];
    end
  end

endmodule

// ===== dv/three_tap_sinc_resampler_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the three-tap sinc resampler: watches both streams and the step register,
// predicts every output sample and compares it with what the block delivers.
// Depends on tsr_pkg and the stream interfaces in tsr_ifs.sv.
module three_tap_sinc_resampler_checker
  import tsr_pkg::*;
#(
  parameter int PHASE_BITS   = 8,
  parameter int MAX_UPSAMPLE = 16
) (
  input  logic                clk,
  input  logic                rst,
  tsr_in_if                   din,
  tsr_out_if                  dout,
  input  logic                cfg_we,
  input  logic [STEP_W-1:0]   cfg_data,
  output int                  mismatches,
  output int                  outstanding
);

  localparam int SPAN = 1 << PHASE_BITS;
  localparam logic [STEP_W-1:0] FLOOR_STEP =
    STEP_W'((65536 + MAX_UPSAMPLE - 1) / MAX_UPSAMPLE);
  localparam int PRINT_LIMIT = 30;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clipped;
    logic                       last;
  } out_sample_t;

  // Tap weights per phase: oldest, middle and newest sample
  int w_prev [SPAN];
  int w_cur  [SPAN];
  int w_next [SPAN];

  logic [STEP_W-1:0]          step_reg;
  logic signed [SAMPLE_W-1:0] hist [3];
  logic [COUNT_W-1:0]         n_taken;
  logic [POS_W-1:0]           out_pos;
  out_sample_t                pending_outputs [$];
  int                         produced;

  // sin(c*t)/(c*t) in Q1.15, t = a / 2^PHASE_BITS, c = 3.142, Taylor series in Q24
  function automatic int sinc_weight(input int unsigned a);
    longint unsigned ang;
    longint          sq;
    longint          term;
    longint          acc;
    longint          mag;
    longint          q;
    ang = ((64'd3142 * a) << 24) / (64'd1000 << PHASE_BITS);
    sq = longint'((ang * ang) >> 24);
    term = Q24_ONE;
    acc = Q24_ONE;
    for (int n = 0; n < SERIES_TERMS; n++) begin
      term = -((term * sq) / Q24_ONE);
      term = term / longint'((2 * n + 2) * (2 * n + 3));
      acc = acc + term;
    end
    mag = (acc < 0) ? -acc : acc;
    q = (mag + 256) / 512;
    if (q > 32768) q = 32768;
    return int'((acc < 0) ? -q : q);
  endfunction

  initial begin
    for (int k = 0; k < SPAN; k++) begin
      w_prev[k] = sinc_weight(k + SPAN);
      w_cur[k]  = sinc_weight(k);
      w_next[k] = sinc_weight(SPAN - k);
    end
  end

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("[%0t] %s", $time, msg);
  endtask

  task automatic clear_stream();
    hist[0] = '0;
    hist[1] = '0;
    hist[2] = '0;
    n_taken = '0;
    out_pos = '0;
  endtask

  task automatic shift_in(input logic signed [SAMPLE_W-1:0] x);
    hist[2] = hist[1];
    hist[1] = hist[0];
    hist[0] = x;
  endtask

  // Emit up to MAX_UPSAMPLE outputs whose position lies below limit, as a wrapping difference
  task automatic emit_until(input logic [POS_W-1:0] limit, input logic [STEP_W-1:0] step);
    logic [POS_W-1:0]      gap;
    logic [PHASE_BITS-1:0] k;
    longint                acc;
    longint                y;
    out_sample_t           o;
    int                    made;
    made = 0;
    while (made < MAX_UPSAMPLE) begin
      gap = limit - out_pos;
      if (gap == '0 || gap[POS_W-1]) break;
      k = out_pos[FRAC_W-1 -: PHASE_BITS];
      acc = longint'(hist[2]) * w_prev[k] + longint'(hist[1]) * w_cur[k]
          + longint'(hist[0]) * w_next[k];
      y = acc / 32768;
      o.clipped = 1'b0;
      o.last = 1'b0;
      if (y > 32767) begin
        y = 32767;
        o.clipped = 1'b1;
      end else if (y < -32768) begin
        y = -32768;
        o.clipped = 1'b1;
      end
      o.sample = SAMPLE_W'(y);
      pending_outputs.push_back(o);
      produced++;
      made++;
      out_pos = out_pos + POS_W'(step);
    end
  endtask

  task automatic take_sample(input logic signed [SAMPLE_W-1:0] x, input logic eod);
    logic [STEP_W-1:0]  step;
    logic [COUNT_W-1:0] n;
    out_sample_t        tail;
    step = (step_reg < FLOOR_STEP) ? FLOOR_STEP : step_reg;
    n = n_taken;
    produced = 0;
    shift_in(x);
    emit_until({n, 16'h0000}, step);
    if (eod) begin
      // flush the tail of the stream with a zero beyond the last sample
      shift_in('0);
      emit_until({n + COUNT_W'(1), 16'h0000}, step);
      clear_stream();
    end else begin
      n_taken = n + COUNT_W'(1);
    end
    if (produced > 0) begin
      tail = pending_outputs.pop_back();
      tail.last = 1'b1;
      pending_outputs.push_back(tail);
    end
  endtask

  always @(posedge clk) begin
    out_sample_t want;
    if (rst) begin
      step_reg = STEP_RESET;
      clear_stream();
      pending_outputs.delete();
    end else begin
      if (cfg_we) step_reg = cfg_data;
      if (din.valid && din.ready) take_sample(din.sample_in, din.end_of_data);
      if (dout.valid && dout.ready) begin
        if (pending_outputs.size() == 0) begin
          report($sformatf("unexpected output: sample %0d clipped %0b last %0b",
                           dout.sample_out, dout.clipped, dout.last_of_run));
        end else begin
          want = pending_outputs.pop_front();
          if (dout.sample_out !== want.sample || dout.clipped !== want.clipped ||
              dout.last_of_run !== want.last) begin
            report($sformatf("output: got sample %0d clipped %0b last %0b, want %0d %0b %0b",
                             dout.sample_out, dout.clipped, dout.last_of_run,
                             want.sample, want.clipped, want.last));
          end
        end
      end
    end
    outstanding = pending_outputs.size();
  end

endmodule

// ===== dv/three_tap_sinc_resampler_top_test.sv =====
`timescale 1ns / 1ps
// Top of the resampler testbench: clock, reset, sample stimulus, step register writes
// and output back-pressure. Depends on tsr_pkg, tsr_ifs.sv and the checker module.
module three_tap_sinc_resampler_top_test;
  import tsr_pkg::*;

  localparam int PHASE_BITS   = 8;
  localparam int MAX_UPSAMPLE = 16;
  localparam int ITEMS_TOTAL  = 360;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES  = 300;
  localparam logic [STEP_W-1:0] STEP_MAX = '1;

  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_THREE_OF_FOUR,
    RX_SPARSE
  } rx_mode_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic [STEP_W-1:0] cfg_data;
  int                mismatches;
  int                outstanding;
  int                items_sent;
  int                burst_left;
  int                gap_due;
  int                hold_req;
  int                hold_left;
  int                rx_tick;
  rx_mode_t          rx_mode;

  tsr_in_if  in_ch ();
  tsr_out_if out_ch ();

  three_tap_sinc_resampler_top #(
    .PHASE_BITS  (PHASE_BITS),
    .MAX_UPSAMPLE(MAX_UPSAMPLE)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .din     (in_ch),
    .dout    (out_ch),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  three_tap_sinc_resampler_checker #(
    .PHASE_BITS  (PHASE_BITS),
    .MAX_UPSAMPLE(MAX_UPSAMPLE)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .din        (in_ch),
    .dout       (out_ch),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always #1 clk = ~clk;

  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Output side: stall pattern that switches between randomly chosen modes
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_left = HOLD_CYCLES;
        hold_req = 0;
      end
      if (rx_tick == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_tick = $urandom_range(16, 96);
      end
      rx_tick--;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS:        out_ch.ready <= 1'b1;
          RX_COIN:          out_ch.ready <= 1'($urandom_range(0, 1));
          RX_THREE_OF_FOUR: out_ch.ready <= (rx_tick % 4 != 0);
          default:          out_ch.ready <= (rx_tick % 5 == 0);
        endcase
      end
    end
  end

  // Offer one sample and hold it until the transaction completes
  task automatic send(input logic signed [SAMPLE_W-1:0] s, input logic eod);
    if (gap_due > 0) begin
      repeat (gap_due) @(posedge clk);
      gap_due = 0;
    end
    in_ch.valid <= 1'b1;
    in_ch.sample_in <= s;
    in_ch.end_of_data <= eod;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap_due = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
    end
    if (gap_due > 0) in_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    if (gap_due == 0) begin
      in_ch.valid <= 1'b0;
      gap_due = 1;
    end
    do @(posedge clk); while (outstanding != 0);
    // an item may produce nothing yet still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_step(input logic [STEP_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0:       return 16'sh7fff;
      1:       return -16'sh8000;
      2:       return SAMPLE_W'($urandom_range(0, 64) - 32);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(0, 9))
      0:       return STEP_W'($urandom_range(0, 4096));
      1:       return STEP_W'(4095 + $urandom_range(0, 2));
      2:       return STEP_W'($urandom_range(1048576, 2097151));
      3:       return STEP_MAX;
      default: return STEP_W'($urandom_range(16384, 196608));
    endcase
  endfunction

  initial begin
    int phase;
    int streams;
    int len;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.sample_in = '0;
    in_ch.end_of_data = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Unity step after reset: field extremes and bit patterns
    send(16'sh7fff, 1'b0);
    send(-16'sh8000, 1'b0);
    send(16'sh0000, 1'b0);
    send(16'sh0001, 1'b0);
    send(-16'sh0001, 1'b0);
    send(16'sh5555, 1'b0);
    send(16'shaaaa, 1'b0);
    send(16'sh3039, 1'b1);
    // stream that ends on its first sample
    send(-16'sh8000, 1'b1);

    // Half step: mid-phase taps on opposing extremes drive the sum into saturation
    wait_idle();
    write_step(STEP_W'(32768));
    send(-16'sh8000, 1'b0);
    send(16'sh7fff, 1'b0);
    send(16'sh7fff, 1'b0);
    send(-16'sh8000, 1'b0);
    send(-16'sh8000, 1'b0);
    send(16'sh7fff, 1'b0);
    send(16'sh7fff, 1'b0);
    send(-16'sh8000, 1'b0);
    send(16'sh7fff, 1'b1);

    // Zero step clamps to the minimum: full upsample count plus full flush
    wait_idle();
    write_step('0);
    send(16'sh7fff, 1'b0);
    send(-16'sh8000, 1'b0);
    send(16'sh0064, 1'b1);

    phase = 0;
    streams = 0;
    while (items_sent < ITEMS_TOTAL) begin
      if (phase < 2 || $urandom_range(0, 3) == 0) begin
        wait_idle();
        case (phase)
          0:       write_step(STEP_W'(4096));
          1:       write_step(STEP_MAX);
          default: write_step(pick_step());
        endcase
        phase++;
      end
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
      if (streams == 0) begin
        // long output stall while samples keep coming
        hold_req = 1;
        len = 36;
      end else if ($urandom_range(0, 11) == 0) begin
        hold_req = 1;
      end
      for (int i = 0; i < len; i++) send(rand_sample(), i == len - 1);
      streams++;
    end

    wait_idle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/tsr_pkg.sv
hw/rtl/tsr_ifs.sv
hw/rtl/tsr_rom.sv
hw/rtl/tsr_mac.sv
hw/rtl/three_tap_sinc_resampler_top.sv
dv/three_tap_sinc_resampler_checker.sv
dv/three_tap_sinc_resampler_top_test.sv
